>>> hdl/mrfl_pkg.sv
// mrfl_pkg: shared types and constants for the rectangle allocator
`timescale 1ns / 1ps
package mrfl_pkg;

    localparam int CoordW = 16;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } rect_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    localparam logic CFG_BIN_WIDTH  = 1'b0;
    localparam logic CFG_BIN_HEIGHT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPL_RD,
        ST_SPL_CHK,
        ST_SPL_MOVE_RD,
        ST_SPL_MOVE_WR,
        ST_PIECE,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_ADD_MV1_RD,
        ST_ADD_MV1_WR,
        ST_ADD_MV2_RD,
        ST_ADD_MV2_WR,
        ST_PR_FRD,
        ST_PR_NRD,
        ST_PR_CHK,
        ST_PR_MV_RD,
        ST_PR_MV_WR,
        ST_MG_RD,
        ST_MG_WR,
        ST_DONE
    } state_t;

    // a inside b, edge sums at 17 bits
    function automatic logic inside_of(rect_t a, rect_t b);
        logic [16:0] ax2;
        logic [16:0] ay2;
        logic [16:0] bx2;
        logic [16:0] by2;
        ax2 = {1'b0, a.x} + {1'b0, a.w};
        ay2 = {1'b0, a.y} + {1'b0, a.h};
        bx2 = {1'b0, b.x} + {1'b0, b.w};
        by2 = {1'b0, b.y} + {1'b0, b.h};
        return (a.x >= b.x) && (a.y >= b.y) && (ax2 <= bx2) && (ay2 <= by2);
    endfunction

endpackage

>>> hdl/mrfl_ram.sv
// mrfl_ram: generic single-port-write, single-read ram with registered read
`timescale 1ns / 1ps
module mrfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/maxrects_free_list_allocator_top.sv
// maxrects_free_list_allocator_top: maxrects best-short-side-fit rectangle allocator
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// in      | into      | in_valid/in_stall  | opcode, req_width, req_height
// out     | out of    | out_valid/out_stall| placed, pos_x, pos_y, overflowed
// cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// one item at a time; a clear goes straight to the done state to show its result
// an insert: a fit scan over the free list, then a split pass that carves each
// overlapped entry into pieces checked against older pieces (removing those a
// piece covers), a prune of new pieces against the surviving free entries, a
// merge, and the result presented; reset leaves one whole-bin entry via entry zero
// in_stall stays high from transfer in until the result transfer completes
module maxrects_free_list_allocator_top #(
    parameter int MAX_FREE = 256,
    parameter int MAX_NEW  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] req_width,
    input  logic [15:0] req_height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        placed,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic        overflowed,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int FAW = $clog2(MAX_FREE);
    localparam int NAW = $clog2(MAX_NEW);
    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int NCW = $clog2(MAX_NEW + 1);

    typedef mrfl_pkg::rect_t rect_t;

    // configuration
    logic [15:0] bin_w_reg, bin_h_reg;

    // free list ram
    logic           f_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    rect_t          f_wdata, f_rdata;
    // new list ram
    logic           n_we;
    logic [NAW-1:0] n_waddr, n_raddr;
    rect_t          n_wdata, n_rdata;

    mrfl_ram #(.WIDTH(64), .DEPTH(MAX_FREE)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    mrfl_ram #(.WIDTH(64), .DEPTH(MAX_NEW)) u_new_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    // entry zero is held in a register while the ram copy is stale after
    // reset or clear: it reads as the whole bin until first written
    logic  zero_ovr_reg, zero_ovr_next;
    rect_t zero_rect_reg, zero_rect_next;
    logic  f_rd_zero_reg;
    rect_t f_rd;
    assign f_rd = (f_rd_zero_reg && zero_ovr_reg) ? zero_rect_reg : f_rdata;

    mrfl_pkg::state_t state_reg, state_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [NCW-1:0] ncnt_reg, ncnt_next;
    logic [NCW-1:0] nold_reg, nold_next;
    logic [FCW-1:0] i_reg, i_next;
    logic [NCW-1:0] j_reg, j_next;
    logic [15:0] w_reg, w_next, h_reg, h_next;
    logic [15:0] bs_reg, bs_next, bl_reg, bl_next;
    logic found_reg, found_next;
    rect_t node_reg, node_next;
    rect_t fr_reg, fr_next;       // free entry under work
    rect_t pc_reg, pc_next;       // piece being added
    logic [1:0] pk_reg, pk_next;  // piece index 0..3
    logic [2:0] pend_reg, pend_next;
    logic drop_reg, drop_next;
    logic placed_reg, placed_next;
    logic [15:0] px_reg, px_next, py_reg, py_next;
    logic ovf_reg, ovf_next;
    logic ov_reg, ov_next;

    // a waiting result blocks the input so the output registers hold still
    assign in_stall   = (state_reg != mrfl_pkg::ST_IDLE) || ov_reg;
    assign out_valid  = ov_reg;
    assign placed     = placed_reg;
    assign pos_x      = px_reg;
    assign pos_y      = py_reg;
    assign overflowed = ovf_reg;

    // split geometry of fr_reg against node_reg
    logic [16:0] fx2, fy2, ux2, uy2;
    logic        ovl;
    logic [3:0]  pvalid;
    rect_t       pieces [4];
    always_comb
    begin
        fx2 = {1'b0, fr_reg.x} + {1'b0, fr_reg.w};
        fy2 = {1'b0, fr_reg.y} + {1'b0, fr_reg.h};
        ux2 = {1'b0, node_reg.x} + {1'b0, node_reg.w};
        uy2 = {1'b0, node_reg.y} + {1'b0, node_reg.h};
        ovl = !(({1'b0, node_reg.x} >= fx2) || (ux2 <= {1'b0, fr_reg.x}) ||
                ({1'b0, node_reg.y} >= fy2) || (uy2 <= {1'b0, fr_reg.y}));
        pvalid[0] = (node_reg.y > fr_reg.y) && ({1'b0, node_reg.y} < fy2);
        pvalid[1] = (uy2 < fy2);
        pvalid[2] = (node_reg.x > fr_reg.x) && ({1'b0, node_reg.x} < fx2);
        pvalid[3] = (ux2 < fx2);
        pieces[0] = '{x: fr_reg.x, y: fr_reg.y, w: fr_reg.w,
                      h: node_reg.y - fr_reg.y};
        pieces[1] = '{x: fr_reg.x, y: uy2[15:0], w: fr_reg.w,
                      h: fy2[15:0] - uy2[15:0]};
        pieces[2] = '{x: fr_reg.x, y: fr_reg.y, w: node_reg.x - fr_reg.x,
                      h: fr_reg.h};
        pieces[3] = '{x: ux2[15:0], y: fr_reg.y, w: fx2[15:0] - ux2[15:0],
                      h: fr_reg.h};
    end

    // fit score
    logic [15:0] lh, lv, sc_s, sc_l;
    logic        fits;
    always_comb
    begin
        fits = (f_rd.w >= w_reg) && (f_rd.h >= h_reg);
        lh   = f_rd.w - w_reg;
        lv   = f_rd.h - h_reg;
        sc_s = (lh < lv) ? lh : lv;
        sc_l = (lh < lv) ? lv : lh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrfl_pkg::ST_IDLE;
            bin_w_reg     <= 16'd1024;
            bin_h_reg     <= 16'd1024;
            zero_ovr_reg  <= 1'b1;
            zero_rect_reg <= '{x: 16'd0, y: 16'd0, w: 16'd1024, h: 16'd1024};
            fcnt_reg      <= FCW'(1);
            ncnt_reg      <= '0;
            nold_reg      <= '0;
            ov_reg        <= 1'b0;
            f_rd_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_ovr_reg  <= zero_ovr_next;
            zero_rect_reg <= zero_rect_next;
            fcnt_reg      <= fcnt_next;
            ncnt_reg      <= ncnt_next;
            nold_reg      <= nold_next;
            ov_reg        <= ov_next;
            f_rd_zero_reg <= (f_raddr == '0);
            if (cfg_we)
            begin
                if (cfg_index == mrfl_pkg::CFG_BIN_WIDTH)
                begin
                    bin_w_reg <= cfg_data;
                end
                else
                begin
                    bin_h_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next;
        w_reg <= w_next; h_reg <= h_next;
        bs_reg <= bs_next; bl_reg <= bl_next;
        found_reg <= found_next; node_reg <= node_next;
        fr_reg <= fr_next; pc_reg <= pc_next;
        pk_reg <= pk_next; pend_reg <= pend_next;
        drop_reg <= drop_next;
        placed_reg <= placed_next; px_reg <= px_next; py_reg <= py_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        zero_ovr_next = zero_ovr_reg; zero_rect_next = zero_rect_reg;
        fcnt_next = fcnt_reg; ncnt_next = ncnt_reg; nold_next = nold_reg;
        i_next = i_reg; j_next = j_reg; w_next = w_reg; h_next = h_reg;
        bs_next = bs_reg; bl_next = bl_reg; found_next = found_reg;
        node_next = node_reg; fr_next = fr_reg; pc_next = pc_reg;
        pk_next = pk_reg; pend_next = pend_reg; drop_next = drop_reg;
        placed_next = placed_reg;
        px_next = px_reg; py_next = py_reg; ovf_next = ovf_reg;
        ov_next = ov_reg;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            mrfl_pkg::ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    w_next = req_width; h_next = req_height;
                    placed_next = 1'b0; px_next = '0; py_next = '0;
                    ovf_next = 1'b0; drop_next = 1'b0;
                    if (opcode == mrfl_pkg::OP_CLEAR)
                    begin
                        zero_ovr_next  = 1'b1;
                        zero_rect_next = '{x: 16'd0, y: 16'd0,
                                           w: bin_w_reg, h: bin_h_reg};
                        fcnt_next = FCW'(1); ncnt_next = '0; nold_next = '0;
                        state_next = mrfl_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next = '0; bs_next = 16'hFFFF; bl_next = 16'hFFFF;
                        found_next = 1'b0;
                        state_next = mrfl_pkg::ST_SCAN_RD;
                    end
                end
            end
            // best short side fit scan
            mrfl_pkg::ST_SCAN_RD:
            begin
                if (i_reg >= fcnt_reg)
                begin
                    if (!found_reg || h_reg == 16'd0)
                    begin
                        state_next = mrfl_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next = '0;
                        state_next = mrfl_pkg::ST_SPL_RD;
                    end
                end
                else
                begin
                    f_raddr = i_reg[FAW-1:0];
                    state_next = mrfl_pkg::ST_SCAN_CHK;
                end
            end
            mrfl_pkg::ST_SCAN_CHK:
            begin
                if (fits && ((sc_s < bs_reg) || (sc_s == bs_reg && sc_l < bl_reg)))
                begin
                    node_next = '{x: f_rd.x, y: f_rd.y, w: w_reg, h: h_reg};
                    bs_next = sc_s; bl_next = sc_l; found_next = 1'b1;
                end
                i_next = i_reg + FCW'(1);
                state_next = mrfl_pkg::ST_SCAN_RD;
            end
            // split pass over free list
            mrfl_pkg::ST_SPL_RD:
            begin
                if (i_reg >= fcnt_reg)
                begin
                    i_next = '0;
                    nold_next = '0;
                    state_next = mrfl_pkg::ST_PR_FRD;
                end
                else
                begin
                    f_raddr = i_reg[FAW-1:0];
                    state_next = mrfl_pkg::ST_SPL_CHK;
                end
            end
            mrfl_pkg::ST_SPL_CHK:
            begin
                fr_next = f_rd;
                state_next = mrfl_pkg::ST_PIECE;
                pk_next = 2'd0;
                pend_next = 3'd0;
            end
            mrfl_pkg::ST_PIECE:
            begin
                // first visit decides overlap
                if (pend_reg == 3'd0)
                begin
                    if (!ovl)
                    begin
                        i_next = i_reg + FCW'(1);
                        state_next = mrfl_pkg::ST_SPL_RD;
                    end
                    else
                    begin
                        nold_next = ncnt_reg;
                        pend_next = 3'd1;
                        pk_next = 2'd0;
                    end
                end
                else if (pend_reg == 3'd5)
                begin
                    // all pieces done: move last free entry into slot i
                    state_next = mrfl_pkg::ST_SPL_MOVE_RD;
                end
                else
                begin
                    if (pvalid[pk_reg])
                    begin
                        pc_next = pieces[pk_reg];
                        j_next = '0;
                        state_next = mrfl_pkg::ST_ADD_RD;
                    end
                    pend_next = pend_reg + 3'd1;
                    pk_next = pk_reg + 2'd1;
                end
            end
            mrfl_pkg::ST_SPL_MOVE_RD:
            begin
                f_raddr = FAW'(fcnt_reg - FCW'(1));
                state_next = mrfl_pkg::ST_SPL_MOVE_WR;
            end
            mrfl_pkg::ST_SPL_MOVE_WR:
            begin
                f_we = 1'b1; f_waddr = i_reg[FAW-1:0]; f_wdata = f_rd;
                if (i_reg == '0)
                begin
                    zero_ovr_next = 1'b0;
                end
                fcnt_next = fcnt_reg - FCW'(1);
                state_next = mrfl_pkg::ST_SPL_RD;
            end
            // add_piece: compare against older new pieces
            mrfl_pkg::ST_ADD_RD:
            begin
                if (j_reg >= nold_reg)
                begin
                    if (ncnt_reg < NCW'(MAX_NEW))
                    begin
                        n_we = 1'b1; n_waddr = ncnt_reg[NAW-1:0]; n_wdata = pc_reg;
                        ncnt_next = ncnt_reg + NCW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    state_next = mrfl_pkg::ST_PIECE;
                end
                else
                begin
                    n_raddr = j_reg[NAW-1:0];
                    state_next = mrfl_pkg::ST_ADD_CHK;
                end
            end
            mrfl_pkg::ST_ADD_CHK:
            begin
                if (mrfl_pkg::inside_of(pc_reg, n_rdata))
                begin
                    state_next = mrfl_pkg::ST_PIECE;
                end
                else if (mrfl_pkg::inside_of(n_rdata, pc_reg))
                begin
                    nold_next = nold_reg - NCW'(1);
                    state_next = mrfl_pkg::ST_ADD_MV1_RD;
                end
                else
                begin
                    j_next = j_reg + NCW'(1);
                    state_next = mrfl_pkg::ST_ADD_RD;
                end
            end
            mrfl_pkg::ST_ADD_MV1_RD:
            begin
                n_raddr = nold_reg[NAW-1:0];
                state_next = mrfl_pkg::ST_ADD_MV1_WR;
            end
            mrfl_pkg::ST_ADD_MV1_WR:
            begin
                n_we = 1'b1; n_waddr = j_reg[NAW-1:0]; n_wdata = n_rdata;
                state_next = mrfl_pkg::ST_ADD_MV2_RD;
            end
            mrfl_pkg::ST_ADD_MV2_RD:
            begin
                n_raddr = NAW'(ncnt_reg - NCW'(1));
                state_next = mrfl_pkg::ST_ADD_MV2_WR;
            end
            mrfl_pkg::ST_ADD_MV2_WR:
            begin
                n_we = 1'b1; n_waddr = nold_reg[NAW-1:0]; n_wdata = n_rdata;
                ncnt_next = ncnt_reg - NCW'(1);
                state_next = mrfl_pkg::ST_ADD_RD;
            end
            // prune new pieces against surviving free entries
            mrfl_pkg::ST_PR_FRD:
            begin
                if (i_reg >= fcnt_reg)
                begin
                    j_next = '0;
                    state_next = mrfl_pkg::ST_MG_RD;
                end
                else
                begin
                    f_raddr = i_reg[FAW-1:0];
                    j_next = '0;
                    state_next = mrfl_pkg::ST_PR_NRD;
                end
            end
            mrfl_pkg::ST_PR_NRD:
            begin
                // free entry i was read in the previous cycle whenever j is zero
                if (j_reg == '0)
                begin
                    fr_next = f_rd;
                end
                if (j_reg >= ncnt_reg)
                begin
                    i_next = i_reg + FCW'(1);
                    state_next = mrfl_pkg::ST_PR_FRD;
                end
                else
                begin
                    n_raddr = j_reg[NAW-1:0];
                    state_next = mrfl_pkg::ST_PR_CHK;
                end
            end
            mrfl_pkg::ST_PR_CHK:
            begin
                if (mrfl_pkg::inside_of(n_rdata, fr_reg))
                begin
                    state_next = mrfl_pkg::ST_PR_MV_RD;
                end
                else
                begin
                    j_next = j_reg + NCW'(1);
                    state_next = mrfl_pkg::ST_PR_NRD;
                end
            end
            mrfl_pkg::ST_PR_MV_RD:
            begin
                n_raddr = NAW'(ncnt_reg - NCW'(1));
                state_next = mrfl_pkg::ST_PR_MV_WR;
            end
            mrfl_pkg::ST_PR_MV_WR:
            begin
                n_we = 1'b1; n_waddr = j_reg[NAW-1:0]; n_wdata = n_rdata;
                ncnt_next = ncnt_reg - NCW'(1);
                // j stays; entry j is read back after the write lands and
                // free entry i is read again so fr reloads right at j zero
                f_raddr = i_reg[FAW-1:0];
                state_next = mrfl_pkg::ST_PR_NRD;
            end
            // merge new pieces into the free list
            mrfl_pkg::ST_MG_RD:
            begin
                if (j_reg >= ncnt_reg)
                begin
                    ncnt_next = '0; nold_next = '0;
                    placed_next = 1'b1; px_next = node_reg.x; py_next = node_reg.y;
                    state_next = mrfl_pkg::ST_DONE;
                end
                else
                begin
                    n_raddr = j_reg[NAW-1:0];
                    state_next = mrfl_pkg::ST_MG_WR;
                end
            end
            mrfl_pkg::ST_MG_WR:
            begin
                if (fcnt_reg < FCW'(MAX_FREE))
                begin
                    f_we = 1'b1; f_waddr = fcnt_reg[FAW-1:0]; f_wdata = n_rdata;
                    if (fcnt_reg == '0)
                    begin
                        zero_ovr_next = 1'b0;
                    end
                    fcnt_next = fcnt_reg + FCW'(1);
                end
                else
                begin
                    drop_next = 1'b1;
                end
                j_next = j_reg + NCW'(1);
                state_next = mrfl_pkg::ST_MG_RD;
            end
            mrfl_pkg::ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ovf_next = placed_reg & drop_reg;
                    ov_next = 1'b1;
                    state_next = mrfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrfl_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCW'(MAX_FREE))
        else $error("free count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        ncnt_reg <= NCW'(MAX_NEW))
        else $error("new count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        nold_reg <= ncnt_reg)
        else $error("older count above new count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrfl_pkg::ST_IDLE) |-> (ncnt_reg == '0))
        else $error("new list not empty when idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !placed) |-> (pos_x == '0 && pos_y == '0))
        else $error("failed result carries a position");

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for the maxrects rectangle allocator
`timescale 1ns / 1ps
module testbench;

    localparam int FREE_DEPTH = 256;
    localparam int NEW_DEPTH  = 64;
    localparam int STALL_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        placed;
        logic [15:0] x;
        logic [15:0] y;
        logic        ovf;
    } alloc_res_t;

    typedef struct {
        mrfl_pkg::opcode_t op;
        logic [15:0]       w;
        logic [15:0]       h;
        bit                known;
        alloc_res_t        res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = 1'b0;
    logic [15:0] req_width = '0;
    logic [15:0] req_height = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        placed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        overflowed;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    maxrects_free_list_allocator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .req_width(req_width), .req_height(req_height),
        .out_valid(out_valid), .out_stall(out_stall),
        .placed(placed), .pos_x(pos_x), .pos_y(pos_y), .overflowed(overflowed),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow copy of the allocator state
    mrfl_pkg::rect_t free_rects [FREE_DEPTH];
    int              free_num;
    mrfl_pkg::rect_t piece_rects [NEW_DEPTH];
    int              piece_num;
    int              piece_old;
    bit              pieces_lost;
    logic [15:0]     bin_w = 16'd1024;
    logic [15:0]     bin_h = 16'd1024;

    alloc_res_t  pending_allocs [$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    // a lies within b, edge sums kept at 17 bits
    function automatic bit lies_within(mrfl_pkg::rect_t a, mrfl_pkg::rect_t b);
        logic [16:0] ax2, ay2, bx2, by2;
        ax2 = a.x + 17'(a.w);
        ay2 = a.y + 17'(a.h);
        bx2 = b.x + 17'(b.w);
        by2 = b.y + 17'(b.h);
        return a.x >= b.x && a.y >= b.y && ax2 <= bx2 && ay2 <= by2;
    endfunction

    function automatic void keep_piece(mrfl_pkg::rect_t r);
        int i;
        i = 0;
        while (i < piece_old)
        begin
            if (lies_within(r, piece_rects[i]))
                return;
            if (lies_within(piece_rects[i], r))
            begin
                piece_old--;
                piece_rects[i] = piece_rects[piece_old];
                piece_rects[piece_old] = piece_rects[piece_num - 1];
                piece_num--;
            end
            else
                i++;
        end
        if (piece_num < NEW_DEPTH)
            piece_rects[piece_num++] = r;
        else
            pieces_lost = 1'b1;
    endfunction

    function automatic mrfl_pkg::rect_t make_rect(int x, int y, int w, int h);
        mrfl_pkg::rect_t r;
        r.x = x[15:0];
        r.y = y[15:0];
        r.w = w[15:0];
        r.h = h[15:0];
        return r;
    endfunction

    // break one free rectangle around the used one, 0 if they do not meet
    function automatic bit carve(mrfl_pkg::rect_t f, mrfl_pkg::rect_t u);
        int fx, fy, fx2, fy2, ux, uy, ux2, uy2;
        fx = f.x; fy = f.y; fx2 = fx + f.w; fy2 = fy + f.h;
        ux = u.x; uy = u.y; ux2 = ux + u.w; uy2 = uy + u.h;
        if (ux >= fx2 || ux2 <= fx || uy >= fy2 || uy2 <= fy)
            return 1'b0;
        piece_old = piece_num;
        if (uy > fy && uy < fy2)
            keep_piece(make_rect(fx, fy, f.w, uy - fy));
        if (uy2 < fy2)
            keep_piece(make_rect(fx, uy2, f.w, fy2 - uy2));
        if (ux > fx && ux < fx2)
            keep_piece(make_rect(fx, fy, ux - fx, f.h));
        if (ux2 < fx2)
            keep_piece(make_rect(ux2, fy, fx2 - ux2, f.h));
        return 1'b1;
    endfunction

    function automatic void occupy(mrfl_pkg::rect_t u);
        int i, j;
        i = 0;
        while (i < free_num)
        begin
            if (carve(free_rects[i], u))
            begin
                free_rects[i] = free_rects[free_num - 1];
                free_num--;
            end
            else
                i++;
        end
        for (i = 0; i < free_num; i++)
        begin
            j = 0;
            while (j < piece_num)
            begin
                if (lies_within(piece_rects[j], free_rects[i]))
                begin
                    piece_rects[j] = piece_rects[piece_num - 1];
                    piece_num--;
                end
                else
                    j++;
            end
        end
        for (j = 0; j < piece_num; j++)
        begin
            if (free_num < FREE_DEPTH)
                free_rects[free_num++] = piece_rects[j];
            else
                pieces_lost = 1'b1;
        end
        piece_num = 0;
        piece_old = 0;
    endfunction

    function automatic void empty_bin();
        free_rects[0] = make_rect(0, 0, bin_w, bin_h);
        free_num = 1;
        piece_num = 0;
        piece_old = 0;
    endfunction

    // best short side fit, ties to the shorter long side, then earliest entry
    function automatic alloc_res_t allocate(mrfl_pkg::opcode_t op, logic [15:0] w,
                                            logic [15:0] h);
        alloc_res_t res;
        int best_short, best_long, lh, lv, s, l;
        bit hit;
        mrfl_pkg::rect_t spot;
        res = '0;
        pieces_lost = 1'b0;
        best_short = 65535;
        best_long = 65535;
        hit = 1'b0;
        spot = '0;
        if (op == mrfl_pkg::OP_CLEAR)
        begin
            empty_bin();
            return res;
        end
        for (int i = 0; i < free_num; i++)
        begin
            if (free_rects[i].w >= w && free_rects[i].h >= h)
            begin
                lh = free_rects[i].w - w;
                lv = free_rects[i].h - h;
                s = lh < lv ? lh : lv;
                l = lh < lv ? lv : lh;
                if (s < best_short || (s == best_short && l < best_long))
                begin
                    spot = make_rect(free_rects[i].x, free_rects[i].y, w, h);
                    best_short = s;
                    best_long = l;
                    hit = 1'b1;
                end
            end
        end
        if (!hit || h == 16'd0)
            return res;
        occupy(spot);
        res.placed = 1'b1;
        res.x = spot.x;
        res.y = spot.y;
        res.ovf = pieces_lost;
        return res;
    endfunction

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // offer one request and wait for its transfer; expectation queued on acceptance
    task automatic offer(mrfl_pkg::opcode_t op, logic [15:0] w, logic [15:0] h,
                         bit known, alloc_res_t typed);
        alloc_res_t predicted;
        opcode <= op;
        req_width <= w;
        req_height <= h;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = allocate(op, w, h);
        pending_allocs = {pending_allocs, (known ? typed : predicted)};
        // random gap after the transfer
        if (!quiet && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
        // every item gives a result, so a small margin is enough
        repeat (20) @(posedge clk);
    endtask

    task automatic set_bin(logic [15:0] w, logic [15:0] h);
        cfg_we <= 1'b1;
        cfg_index <= mrfl_pkg::CFG_BIN_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= mrfl_pkg::CFG_BIN_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        bin_w = w;
        bin_h = h;
    endtask

    task automatic random_request();
        int pick, wl, hl;
        pick = $urandom_range(99);
        wl = bin_w / 3;
        hl = bin_h / 3;
        if (hl < 1)
            hl = 1;
        if (pick < 5)
            offer(mrfl_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
        else if (pick < 12)
            offer(mrfl_pkg::OP_INSERT, 16'($urandom), 16'($urandom), 1'b0, '0);
        else if (pick < 17)
            offer(mrfl_pkg::OP_INSERT, 16'($urandom), 16'd0, 1'b0, '0);
        else
            offer(mrfl_pkg::OP_INSERT, 16'($urandom_range(0, wl)),
                  16'($urandom_range(1, hl)), 1'b0, '0);
    endtask

    // directed rows: typed results only after reset, at the extremes and after a clear
    stim_row_t directed [] = '{
        '{mrfl_pkg::OP_INSERT, 16'd16,    16'd0,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd0,     16'd0,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd1024,  16'd1024, 1'b1, '{1'b1, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd1,     16'd1,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_CLEAR,  16'hffff,  16'hffff, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd0,     16'd7,    1'b1, '{1'b1, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'hffff,  16'hffff, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd1025,  16'd1,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd32768, 16'd1,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_CLEAR,  16'd0,     16'd0,    1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd100,   16'd50,   1'b1, '{1'b1, 16'd0, 16'd0, 1'b0}},
        '{mrfl_pkg::OP_INSERT, 16'd200,   16'd30,   1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd924,   16'd974,  1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd0,     16'd20,   1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd50,    16'd50,   1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd300,   16'd1,    1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd1,     16'd300,  1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd724,   16'd50,   1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd1024,  16'd1,    1'b0, '0},
        '{mrfl_pkg::OP_INSERT, 16'd10,    16'd10,   1'b0, '0}
    };

    // stimulus
    initial
    begin
        logic [15:0] bins_w [5];
        logic [15:0] bins_h [5];
        empty_bin();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            offer(directed[k].op, directed[k].w, directed[k].h, directed[k].known,
                  directed[k].res);
        drain();

        // extreme and random bin sizes; the last phase returns to the reset size
        bins_w = '{16'd1, 16'hffff, 16'($urandom_range(1, 65535)), 16'd300, 16'd1024};
        bins_h = '{16'd1, 16'hffff, 16'($urandom_range(1, 65535)), 16'd200, 16'd1024};
        for (int p = 0; p < 5; p++)
        begin
            set_bin(bins_w[p], bins_h[p]);
            // the new size only counts from the next clear
            offer(mrfl_pkg::OP_INSERT, 16'd1, 16'd1, 1'b0, '0);
            offer(mrfl_pkg::OP_CLEAR, 16'd0, 16'd0, 1'b0, '0);
            if (p == 2)
                hold_req = 1'b1;
            if (p == 4)
                quiet = 1'b1;
            repeat (18)
                random_request();
            // sender waits for every result before touching the registers
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver back-pressure: random bursts, one long hold-off, none at the end
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result checker against the oldest expectation
    always @(posedge clk)
    begin
        alloc_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_allocs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer placed=%0d x=%0d y=%0d ovf=%0d",
                             placed, pos_x, pos_y, overflowed);
            end
            else
            begin
                want = pending_allocs.pop_front();
                if (want.placed !== placed || want.x !== pos_x || want.y !== pos_y
                        || want.ovf !== overflowed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected placed=%0d x=%0d y=%0d ovf=%0d,",
                               want.placed, want.x, want.y, want.ovf);
                        $display(" got placed=%0d x=%0d y=%0d ovf=%0d",
                                 placed, pos_x, pos_y, overflowed);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

>>> maxrects_free_list_allocator_top.f
hdl/mrfl_pkg.sv
hdl/mrfl_ram.sv
hdl/maxrects_free_list_allocator_top.sv
sim/testbench.sv
